FILE: hdl/xcfb_pkg.sv
// shared types and constants of the xor checked frame builder
package xcfb_pkg;

  localparam int ByteW = 8;
  localparam int WordW = 16;
  localparam int CfgIdxW = 8;
  localparam int CmdQueueDepth = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_HEADER = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_TAIL = 8'd1;

  // byte pair being sent by the back end
  localparam logic [1:0] SEG_HEAD = 2'd0;
  localparam logic [1:0] SEG_WORD = 2'd1;
  localparam logic [1:0] SEG_CHK = 2'd2;

  typedef struct packed {
    logic             first;
    logic             present;
    logic             last;
    logic [ByteW-1:0] func;
    logic [WordW-1:0] word;
  } cmd_t;

endpackage

FILE: hdl/xcfb_front.sv
// front end: tracks the open frame and drops items that produce no bytes
module xcfb_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [xcfb_pkg::ByteW-1:0]   func_code_i,
  input  logic signed [xcfb_pkg::WordW-1:0] data_word_i,
  input  logic                         first_word_i,
  input  logic                         last_word_i,
  input  logic                         word_present_i,
  input  logic                         cmd_full_i,
  output logic                         cmd_push_o,
  output xcfb_pkg::cmd_t               cmd_o
);

  logic in_frame_q, in_frame_d;
  logic accept;
  logic live;

  assign full = cmd_full_i;
  assign accept = push && !cmd_full_i;
  // an item counts if it opens a frame or arrives inside one
  assign live = first_word_i || in_frame_q;

  assign cmd_push_o = accept && live && (first_word_i || word_present_i || last_word_i);

  assign cmd_o.first = first_word_i;
  assign cmd_o.present = word_present_i;
  assign cmd_o.last = last_word_i;
  assign cmd_o.func = func_code_i;
  assign cmd_o.word = $unsigned(data_word_i);

  always_comb begin
    in_frame_d = in_frame_q;
    if (accept && live) begin
      in_frame_d = !last_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
    end
  end

endmodule

FILE: hdl/xcfb_cmd_fifo.sv
// short command queue between the front and back ends
module xcfb_cmd_fifo #(
  parameter int Depth = xcfb_pkg::CmdQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xcfb_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output xcfb_pkg::cmd_t data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  xcfb_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic do_push, do_pop;

  assign full_o = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/xcfb_back.sv
// back end: walks each command byte by byte, keeps the checksum, drives the output register
module xcfb_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [xcfb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [xcfb_pkg::ByteW-1:0]    cfg_data_i,
  input  logic                          cmd_empty_i,
  input  xcfb_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  input  logic                          pop,
  output logic                          empty,
  output logic [xcfb_pkg::ByteW-1:0]    out_byte_o,
  output logic                          frame_end_o
);

  logic [xcfb_pkg::ByteW-1:0] header_q, tail_q;
  xcfb_pkg::cmd_t cur_q, cur_d;
  logic cur_valid_q, cur_valid_d;
  logic [1:0] seg_q, seg_d;
  logic half_q, half_d;
  logic [xcfb_pkg::ByteW-1:0] xor_q, xor_d;
  logic out_valid_q, out_valid_d;
  logic [xcfb_pkg::ByteW-1:0] out_byte_q, out_byte_d;
  logic out_end_q, out_end_d;

  logic [xcfb_pkg::ByteW-1:0] byte_val;
  logic byte_end;
  logic seg_done, advance, load;
  logic [1:0] start_seg;

  assign empty = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign frame_end_o = out_end_q;

  always_comb begin
    byte_val = '0;
    byte_end = 1'b0;
    case (seg_q)
      xcfb_pkg::SEG_HEAD: byte_val = half_q ? cur_q.func : header_q;
      xcfb_pkg::SEG_WORD: byte_val = half_q ? cur_q.word[7:0] : cur_q.word[15:8];
      xcfb_pkg::SEG_CHK: begin
        byte_val = half_q ? tail_q : xor_q;
        byte_end = half_q;
      end
      default: byte_val = '0;
    endcase
  end

  // last byte of the current command
  assign seg_done = half_q && ((seg_q == xcfb_pkg::SEG_CHK)
                    || (seg_q == xcfb_pkg::SEG_WORD && !cur_q.last)
                    || (seg_q == xcfb_pkg::SEG_HEAD && !cur_q.present && !cur_q.last));
  assign advance = cur_valid_q && (!out_valid_q || pop);
  assign load = !cmd_empty_i && (!cur_valid_q || (advance && seg_done));
  assign cmd_pop_o = load;
  assign start_seg = cmd_i.first ? xcfb_pkg::SEG_HEAD :
                     cmd_i.present ? xcfb_pkg::SEG_WORD : xcfb_pkg::SEG_CHK;

  always_comb begin
    cur_d = cur_q;
    cur_valid_d = cur_valid_q;
    seg_d = seg_q;
    half_d = half_q;
    xor_d = xor_q;
    out_valid_d = out_valid_q;
    out_byte_d = out_byte_q;
    out_end_d = out_end_q;

    if (out_valid_q && pop) begin
      out_valid_d = 1'b0;
    end

    if (advance) begin
      out_valid_d = 1'b1;
      out_byte_d = byte_val;
      out_end_d = byte_end;
      // header restarts the checksum, the tail is not part of it
      if (seg_q == xcfb_pkg::SEG_HEAD && !half_q) begin
        xor_d = byte_val;
      end else if (!byte_end) begin
        xor_d = xor_q ^ byte_val;
      end
      if (seg_done) begin
        cur_valid_d = 1'b0;
      end else if (!half_q) begin
        half_d = 1'b1;
      end else begin
        half_d = 1'b0;
        seg_d = (seg_q == xcfb_pkg::SEG_HEAD && cur_q.present) ?
                xcfb_pkg::SEG_WORD : xcfb_pkg::SEG_CHK;
      end
    end

    if (load) begin
      cur_d = cmd_i;
      cur_valid_d = 1'b1;
      seg_d = start_seg;
      half_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_byte_q <= out_byte_d;
    out_end_q <= out_end_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= '0;
      tail_q <= '0;
      cur_valid_q <= 1'b0;
      seg_q <= xcfb_pkg::SEG_HEAD;
      half_q <= 1'b0;
      xor_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == xcfb_pkg::REG_HEADER) begin
        header_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == xcfb_pkg::REG_TAIL) begin
        tail_q <= cfg_data_i;
      end
      cur_valid_q <= cur_valid_d;
      seg_q <= seg_d;
      half_q <= half_d;
      xor_q <= xor_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/xor_checked_frame_builder.sv
// top level of the xor checked frame builder
// Turns payload words into a byte frame: header and function code on the first item,
// each present word high byte first, then on the last item an XOR checksum of all
// earlier frame bytes and the tail byte, flagged by frame_end_o. Items are taken one
// per cycle while the command queue (CmdDepth entries) has room; the output register
// sends one byte per cycle while pop is high. A plain word makes 2 bytes, and an
// item that opens and closes a frame up to 6. The first byte of an item goes through
// the command queue and the current-command register to the output register.
// Items outside an open frame, and word-less items in mid-frame that do not close it,
// produce nothing. Header and tail registers are written through the cfg channel,
// which is always ready; the user must write them only while no item is in flight,
// not enforced by the block; index 0 is the header, index 1 the tail, others ignored.
module xor_checked_frame_builder #(
  parameter int CmdDepth = xcfb_pkg::CmdQueueDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [xcfb_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [xcfb_pkg::ByteW-1:0]         cfg_data_i,
  input  logic                               push,
  output logic                               full,
  input  logic [xcfb_pkg::ByteW-1:0]         func_code_i,
  input  logic signed [xcfb_pkg::WordW-1:0]  data_word_i,
  input  logic                               first_word_i,
  input  logic                               last_word_i,
  input  logic                               word_present_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [xcfb_pkg::ByteW-1:0]         out_byte_o,
  output logic                               frame_end_o
);

  logic cmd_full, cmd_push, cmd_empty, cmd_pop;
  xcfb_pkg::cmd_t cmd_in, cmd_head;

  assign cfg_ready_o = 1'b1;

  xcfb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .func_code_i    (func_code_i),
    .data_word_i    (data_word_i),
    .first_word_i   (first_word_i),
    .last_word_i    (last_word_i),
    .word_present_i (word_present_i),
    .cmd_full_i     (cmd_full),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in)
  );

  xcfb_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_head)
  );

  xcfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o)
  );

endmodule

FILE: hdl/xcfb_checker.sv
// port level checks of the xor checked frame builder and their bind
module xcfb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       push,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [xcfb_pkg::ByteW-1:0] out_byte_o,
  input logic                       frame_end_o
);

  // a waiting byte holds until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(frame_end_o)))
    else $error("output byte changed while stalled");

  // a checksum always separates two tail bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && frame_end_o) |=> (empty || !frame_end_o))
    else $error("two tail bytes in a row");

  // the queue only fills through accepted items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> ($past(push && !full) || $past(full)))
    else $error("full without an accepted item");

  // leaving reset the block is empty and ready
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("state not cleared by reset");

endmodule

bind xor_checked_frame_builder xcfb_checker u_xcfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_byte_o  (out_byte_o),
  .frame_end_o (frame_end_o)
);

FILE: dv/xor_checked_frame_builder_test.sv
// self-checking testbench of the xor checked frame builder
`timescale 1ns / 100ps

module xor_checked_frame_builder_test;
  import xcfb_pkg::*;

  typedef struct {
    logic [ByteW-1:0]        func;
    logic signed [WordW-1:0] word;
    logic                    first;
    logic                    last;
    logic                    present;
  } frame_item_t;

  // predicts the byte stream of each frame and checks what leaves the block
  class frame_scoreboard;
    logic [ByteW-1:0] header_val;
    logic [ByteW-1:0] tail_val;
    logic [ByteW-1:0] xor_acc;
    bit               frame_open;
    logic [ByteW:0]   bytes_due[$];  // {frame_end, byte}
    int               errors;
    int               framed_items;

    function new();
      header_val = '0;
      tail_val = '0;
      xor_acc = '0;
      frame_open = 0;
      errors = 0;
      framed_items = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      if (idx == REG_HEADER) header_val = val;
      else if (idx == REG_TAIL) tail_val = val;
    endfunction

    function void emit(logic [ByteW-1:0] b, bit is_tail);
      bytes_due.push_back({is_tail, b});
      if (!is_tail) xor_acc ^= b;
    endfunction

    function void note_item(frame_item_t it);
      if (it.first) begin
        xor_acc = '0;
        frame_open = 1;
        emit(header_val, 0);
        emit(it.func, 0);
      end else if (!frame_open) begin
        return;
      end
      framed_items++;
      if (it.present) begin
        emit(it.word[15:8], 0);
        emit(it.word[7:0], 0);
      end
      if (it.last) begin
        emit(xor_acc, 0);
        emit(tail_val, 1);
        frame_open = 0;
      end
    endfunction

    task report(string what, logic [ByteW:0] got, logic [ByteW:0] want);
      // keep the log short when everything goes wrong
      if (errors < 100)
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
    endtask

    task check_byte(logic [ByteW-1:0] b, logic fe);
      logic [ByteW:0] want;
      if (bytes_due.size() == 0) begin
        report("byte with nothing due", {fe, b}, '0);
      end else begin
        want = bytes_due.pop_front();
        if (b !== want[ByteW-1:0]) report("out_byte", {1'b0, b}, {1'b0, want[ByteW-1:0]});
        if (fe !== want[ByteW]) begin
          report("frame_end", {{ByteW{1'b0}}, fe}, {{ByteW{1'b0}}, want[ByteW]});
        end
      end
    endtask
  endclass

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i = '0;
  logic [ByteW-1:0]          cfg_data_i = '0;
  logic                      push = 1'b0;
  logic                      full;
  logic [ByteW-1:0]          func_code_i = '0;
  logic signed [WordW-1:0]   data_word_i = '0;
  logic                      first_word_i = 1'b0;
  logic                      last_word_i = 1'b0;
  logic                      word_present_i = 1'b0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [ByteW-1:0]          out_byte_o;
  logic                      frame_end_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  frame_scoreboard sb;

  xor_checked_frame_builder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .func_code_i    (func_code_i),
    .data_word_i    (data_word_i),
    .first_word_i   (first_word_i),
    .last_word_i    (last_word_i),
    .word_present_i (word_present_i),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .frame_end_o    (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  // both handshakes are sampled at the edge, before any flop update lands
  always @(posedge clk_i) begin : monitor
    frame_item_t seen;
    if (rst_ni) begin
      if (push && !full) begin
        seen.func = func_code_i;
        seen.word = data_word_i;
        seen.first = first_word_i;
        seen.last = last_word_i;
        seen.present = word_present_i;
        sb.note_item(seen);
      end
      if (pop && !empty) sb.check_byte(out_byte_o, frame_end_o);
    end
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic frame_item_t mk_item(logic [7:0] f, logic [15:0] w,
                                          logic fi, logic la, logic pr);
    frame_item_t it;
    it.func = f;
    it.word = w;
    it.first = fi;
    it.last = la;
    it.present = pr;
    return it;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(11))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(frame_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    func_code_i <= it.func;
    data_word_i <= it.word;
    first_word_i <= it.first;
    last_word_i <= it.last;
    word_present_i <= it.present;
    do @(posedge clk_i); while (full);
  endtask

  // only written once the frame path has gone quiet
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
    push <= 1'b0;
    // let the monitor note the last accepted item first
    @(posedge clk_i);
    while (sb.bytes_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int n_items);
    int goal;
    int len;
    bit close_it;
    goal = sb.framed_items + n_items;
    while (sb.framed_items < goal) begin
      if ($urandom_range(99) < 10) begin
        // noise: any combination of marks, often outside a frame
        send_item(mk_item(8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom)));
      end else begin
        len = $urandom_range(1, 5);
        close_it = ($urandom_range(99) >= 6);
        for (int i = 0; i < len; i++) begin
          send_item(mk_item(8'($urandom), pick_word(), i == 0,
                            close_it && (i == len - 1), $urandom_range(99) < 85));
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(REG_HEADER, 8'hA5);
    write_reg(REG_TAIL, 8'h3C);
    write_reg(8'hFF, 8'h99);  // unused index, must change nothing

    // items outside any frame, with and without the last mark
    send_item(mk_item(8'h11, 16'h1234, 1'b0, 1'b0, 1'b1));
    send_item(mk_item(8'h22, 16'h5678, 1'b0, 1'b1, 1'b1));
    // frame with no words
    send_item(mk_item(8'h00, 16'hFFFF, 1'b1, 1'b1, 1'b0));
    send_item(mk_item(8'hFF, 16'h7FFF, 1'b1, 1'b0, 1'b1));
    send_item(mk_item(8'h00, 16'h8000, 1'b0, 1'b0, 1'b1));
    // word-less item in mid-frame
    send_item(mk_item(8'h5A, 16'h0F0F, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(8'h00, 16'hFFFF, 1'b0, 1'b1, 1'b1));
    send_item(mk_item(8'h80, 16'h0000, 1'b1, 1'b0, 1'b1));
    // restart while a frame is open
    send_item(mk_item(8'h01, 16'h00FF, 1'b1, 1'b0, 1'b1));
    send_item(mk_item(8'h00, 16'h1111, 1'b0, 1'b1, 1'b0));
    send_item(mk_item(8'hC3, 16'hA55A, 1'b1, 1'b1, 1'b1));
    send_item(mk_item(8'hFF, 16'h0000, 1'b1, 1'b1, 1'b0));
    send_item(mk_item(8'h7E, 16'h0001, 1'b1, 1'b0, 1'b0));
    send_item(mk_item(8'h00, 16'hFE00, 1'b1, 1'b1, 1'b1));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_HEADER, 8'hFF);
          write_reg(REG_TAIL, 8'h00);
        end
        1: begin
          write_reg(REG_HEADER, 8'h00);
          write_reg(REG_TAIL, 8'hFF);
        end
        default: begin
          write_reg(REG_HEADER, 8'($urandom));
          write_reg(REG_TAIL, 8'($urandom));
        end
      endcase
      send_idle_pct = (ph == 1) ? 86 : (ph == 3) ? 38 : 0;
      recv_stall_pct = (ph == 2) ? 86 : (ph == 3) ? 38 : 0;
      run_random(78);
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (sb.bytes_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0 && sb.bytes_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/xcfb_pkg.sv
hdl/xcfb_front.sv
hdl/xcfb_cmd_fifo.sv
hdl/xcfb_back.sv
hdl/xor_checked_frame_builder.sv
hdl/xcfb_checker.sv
dv/xor_checked_frame_builder_test.sv
